// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the scratchpad CRC checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TSCC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

// Checks that a consequent holds in the same cycle as its antecedent.
`define TSCC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// ===== rtl/tscc_pkg.sv =====
// Shared constants, request codes and rounding function for the scratchpad CRC checker.
package tscc_pkg;

	// Request kinds carried on the kind field.
	localparam logic [1:0] KindByte     = 2'd0;
	localparam logic [1:0] KindPresFail = 2'd1;
	localparam logic [1:0] KindConsume  = 2'd2;

	// Reflected CRC-8 polynomial and frame geometry.
	localparam logic [7:0] CrcPoly    = 8'h8C;
	localparam int         FrameBytes = 9;
	localparam logic [3:0] LastIndex  = 4'(FrameBytes - 1);

	// Converts sixteenths of a degree to whole degrees, rounding half away from zero.
	function automatic logic signed [12:0] round_degrees(input logic signed [15:0] raw);
		logic [16:0] mag;
		logic [16:0] sum;
		logic [12:0] q;
		mag = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
		sum = mag + 17'd8;
		q   = sum[16:4];
		return raw[15] ? 13'(13'd0 - q) : q;
	endfunction

endpackage

// ===== rtl/temp_scratchpad_crc_checker.sv =====
// Top level of the temperature sensor scratchpad frame checker.
//
// Each request carries one scratchpad byte, a bus presence failure or a consume
// request, and gives exactly one result. A request passes an input register and
// then combinational logic (the unrolled byte-wide CRC-8 update and the rounding
// of the raw temperature) into the result register, so the block takes one
// request per clock as long as out_ready does not hold a result back, and a
// result is presented from the result register after its request has passed
// through the input register. The block holds at most two requests in flight;
// while a finished result waits, the input stays ready only as long as the
// input register is empty, and out_ready reaches in_ready through logic.
// A frame is nine bytes: CRC over bytes 0 to 7, compared with byte 8.
module temp_scratchpad_crc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               frame_done,
	output logic               crc_ok,
	output logic signed [15:0] raw_temperature,
	output logic signed [12:0] temperature,
	output logic               temp_returned,
	output logic               temp_valid,
	output logic               temp_fresh
);
	import tscc_pkg::*;

	`include "assert_macros.svh"

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic [3:0]  byte_index_q;
	logic [7:0]  running_crc_q;
	logic [7:0]  raw_low_q;
	logic [7:0]  raw_high_q;
	logic signed [12:0] stored_temp_q;
	logic        valid_flag_q;
	logic        fresh_flag_q;

	logic [3:0]  byte_index_d;
	logic [7:0]  running_crc_d;
	logic [7:0]  raw_low_d;
	logic [7:0]  raw_high_d;
	logic signed [12:0] stored_temp_d;
	logic        valid_flag_d;
	logic        fresh_flag_d;
	logic        done_d;
	logic        ok_d;
	logic        returned_d;
	logic [7:0]  crc_upd;

	logic        out_valid_q;
	logic        frame_done_q;
	logic        crc_ok_q;
	logic [15:0] raw_temp_q;
	logic signed [12:0] temp_q;
	logic        returned_q;
	logic        temp_valid_q;
	logic        new_data_q;

	// The input register moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			byte_s1 <= rx_byte;
		end
	end

	tscc_crc8 u_crc8 (
		.crc_in  (running_crc_q),
		.data_in (byte_s1),
		.crc_out (crc_upd)
	);

	// Request decode and next state.
	always_comb begin
		byte_index_d  = byte_index_q;
		running_crc_d = running_crc_q;
		raw_low_d     = raw_low_q;
		raw_high_d    = raw_high_q;
		stored_temp_d = stored_temp_q;
		valid_flag_d  = valid_flag_q;
		fresh_flag_d  = fresh_flag_q;
		done_d        = 1'b0;
		ok_d          = 1'b0;
		returned_d    = 1'b0;
		unique case (kind_s1)
			KindByte: begin
				if (byte_index_q >= LastIndex) begin
					done_d        = 1'b1;
					ok_d          = (running_crc_q == byte_s1);
					stored_temp_d = ok_d ? round_degrees({raw_high_q, raw_low_q})
							: stored_temp_q;
					valid_flag_d  = ok_d;
					fresh_flag_d  = ok_d;
					byte_index_d  = '0;
					running_crc_d = '0;
				end else begin
					if (byte_index_q == 4'd0) begin
						raw_low_d = byte_s1;
					end
					if (byte_index_q == 4'd1) begin
						raw_high_d = byte_s1;
					end
					running_crc_d = crc_upd;
					byte_index_d  = byte_index_q + 4'd1;
				end
			end
			KindPresFail: begin
				byte_index_d  = '0;
				running_crc_d = '0;
				valid_flag_d  = 1'b0;
				fresh_flag_d  = 1'b0;
			end
			KindConsume: begin
				if (valid_flag_q) begin
					returned_d   = 1'b1;
					fresh_flag_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			running_crc_q <= '0;
			raw_low_q     <= '0;
			raw_high_q    <= '0;
			stored_temp_q <= '0;
			valid_flag_q  <= 1'b0;
			fresh_flag_q  <= 1'b0;
		end else if (advance) begin
			byte_index_q  <= byte_index_d;
			running_crc_q <= running_crc_d;
			raw_low_q     <= raw_low_d;
			raw_high_q    <= raw_high_d;
			stored_temp_q <= stored_temp_d;
			valid_flag_q  <= valid_flag_d;
			fresh_flag_q  <= fresh_flag_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_done_q <= done_d;
			crc_ok_q     <= ok_d;
			raw_temp_q   <= {raw_high_d, raw_low_d};
			temp_q       <= stored_temp_d;
			returned_q   <= returned_d;
			temp_valid_q <= valid_flag_d;
			new_data_q   <= fresh_flag_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_done      = frame_done_q;
	assign crc_ok          = crc_ok_q;
	assign raw_temperature = raw_temp_q;
	assign temperature     = temp_q;
	assign temp_returned   = returned_q;
	assign temp_valid      = temp_valid_q;
	assign temp_fresh      = new_data_q;

	// The frame position never passes the check byte.
	`TSCC_ASSERT_ALWAYS(a_index_range, byte_index_q <= LastIndex)
	// Fresh data is always valid data.
	`TSCC_ASSERT_IMPLIES(a_fresh_valid, fresh_flag_q, valid_flag_q)
	// A good CRC is only reported on the last byte of a frame.
	`TSCC_ASSERT_IMPLIES(a_ok_done, out_valid_q && crc_ok_q, frame_done_q)
	// A returned temperature comes with the valid flag still set.
	`TSCC_ASSERT_IMPLIES(a_ret_valid, out_valid_q && returned_q, temp_valid_q)

endmodule

// ===== rtl/tscc_crc8.sv =====
// One-byte update of the reflected CRC-8, unrolled over the eight bits.
module tscc_crc8 (
	input  logic [7:0] crc_in,
	input  logic [7:0] data_in,
	output logic [7:0] crc_out
);
	import tscc_pkg::*;

	// Shift the byte in least significant bit first.
	always_comb begin
		logic [7:0] crc;
		logic [7:0] b;
		crc = crc_in;
		b   = data_in;
		for (int k = 0; k < 8; k++) begin
			if ((crc[0] ^ b[0]) == 1'b1) begin
				crc = (crc >> 1) ^ CrcPoly;
			end else begin
				crc = crc >> 1;
			end
			b = b >> 1;
		end
		crc_out = crc;
	end

endmodule
